@@ hw/rtl/afns_pkg.sv @@
// Shared types and constants for the aspect-fit nearest scaler.
// No dependencies; used by every module in hw/rtl.
package afns_pkg;

	localparam int CoordW = 12;
	localparam int PixW   = 32;
	localparam int CfgW   = 12;
	localparam int CfgIdxW = 2;

	// operation codes
	localparam logic OpWrite = 1'b0;
	localparam logic OpRead  = 1'b1;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgDispWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDispHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgImgWidth   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgImgHeight  = 2'd3;

	// fitted geometry, recomputed after each configuration write
	typedef struct packed {
		logic [CoordW-1:0] fw;
		logic [CoordW-1:0] fh;
		logic [CoordW-1:0] xo;
		logic [CoordW-1:0] yo;
		logic              en;
	} geom_t;

	// per-item sideband that travels next to the dividers
	typedef struct packed {
		logic              op;
		logic              hit;
		logic              wr_ok;
		logic [CoordW-1:0] cx;
		logic [CoordW-1:0] cy;
		logic [PixW-1:0]   pix;
	} side_t;

endpackage

@@ hw/rtl/afns_geom.sv @@
// Fit geometry unit: fitted size and centering offsets from the registers.
// Uses afns_pkg; one shared restoring divider, one quotient bit a cycle.
module afns_geom #(
	parameter int DW = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      kick,
	input  logic [afns_pkg::CfgW-1:0] dw,
	input  logic [afns_pkg::CfgW-1:0] dh,
	input  logic [DW-1:0]             sw,
	input  logic [DW-1:0]             sh,
	output logic                      busy,
	output afns_pkg::geom_t           geom
);

	localparam int PW = afns_pkg::CfgW + DW;
	localparam int QW = afns_pkg::CoordW;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CMP, ST_DIV, ST_FIN} state_t;

	state_t          state_q;
	logic [PW-1:0]   pw_q, ph_q;
	logic            zero_q, wide_q;
	logic [DW-1:0]   den_q, rem_q;
	logic [QW-1:0]   low_q, quo_q;
	logic [3:0]      cnt_q;
	afns_pkg::geom_t geom_q;

	logic [PW-1:0]   num;
	logic [DW:0]     t, diff;
	logic            ge;
	logic [QW-1:0]   fit_w, fit_h, fw1, fh1;

	assign num   = (pw_q <= ph_q) ? pw_q : ph_q;
	assign t     = {rem_q, low_q[QW-1]};
	assign ge    = t >= {1'b0, den_q};
	assign diff  = t - {1'b0, den_q};
	assign fit_w = wide_q ? dw : quo_q;
	assign fit_h = wide_q ? quo_q : dh;
	assign fw1   = (fit_w == '0) ? QW'(1) : fit_w;
	assign fh1   = (fit_h == '0) ? QW'(1) : fit_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
			geom_q  <= '0;
			cnt_q   <= '0;
		end else if (kick) begin
			state_q <= ST_MUL;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_MUL: begin
					pw_q    <= PW'(dw) * PW'(sh);
					ph_q    <= PW'(dh) * PW'(sw);
					zero_q  <= (dw == '0) || (dh == '0) || (sw == '0) || (sh == '0);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					wide_q  <= pw_q <= ph_q;
					den_q   <= (pw_q <= ph_q) ? sw : sh;
					rem_q   <= num[PW-1:QW];
					low_q   <= num[QW-1:0];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
					low_q <= low_q << 1;
					quo_q <= {quo_q[QW-2:0], ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(QW - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					geom_q.fw <= fw1;
					geom_q.fh <= fh1;
					geom_q.xo <= (dw - fw1) >> 1;
					geom_q.yo <= (dh - fh1) >> 1;
					geom_q.en <= !zero_q;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign geom = geom_q;

endmodule

@@ hw/rtl/afns_divpipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Uses afns_pkg; divisor must stay steady while items are in flight.
module afns_divpipe #(
	parameter int NW = 22,
	parameter int D  = 9
) (
	input  logic                        clk,
	input  logic [NW-1:0]               num,
	input  logic [afns_pkg::CoordW-1:0] den,
	output logic [D-1:0]                quo
);

	localparam int RW = afns_pkg::CoordW;

	logic [RW-1:0] rem_s [D+1];
	logic [D-1:0]  low_s [D+1];
	logic [D-1:0]  quo_s [D+1];

	// quotient fits D bits, so the upper part is already below den
	assign rem_s[0] = RW'(num >> D);
	assign low_s[0] = num[D-1:0];
	assign quo_s[0] = '0;

	for (genvar k = 0; k < D; k++) begin : g_stage
		logic [RW:0] t, diff;
		logic        ge;
		assign t    = {rem_s[k], low_s[k][D-1]};
		assign ge   = t >= {1'b0, den};
		assign diff = t - {1'b0, den};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[RW-1:0] : t[RW-1:0];
			low_s[k+1] <= low_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][D-2:0], ge};
		end
	end

	assign quo = quo_s[D];

endmodule

@@ hw/rtl/aspect_fit_nearest_scaler_unit.sv @@
// Top level of the aspect-fit nearest-neighbor scaler with letterboxing.
// Uses afns_pkg, afns_geom and afns_divpipe; holds the source frame memory.
module aspect_fit_nearest_scaler_unit #(
	parameter int MAX_SOURCE_WIDTH  = 512,
	parameter int MAX_SOURCE_HEIGHT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [afns_pkg::CoordW-1:0]  coord_x,
	input  logic [afns_pkg::CoordW-1:0]  coord_y,
	input  logic [afns_pkg::PixW-1:0]    pixel_in,
	input  logic                         cfg_we,
	input  logic [afns_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [afns_pkg::CfgW-1:0]    cfg_data,
	output logic                         done,
	output logic [afns_pkg::PixW-1:0]    pixel_out,
	output logic                         inside_image
);

	// Usage: one transfer per clock while busy is low. op 0 stores pixel_in at
	// (coord_x, coord_y) of the source frame; op 1 reads display pixel
	// (coord_x, coord_y) and returns pixel_out / inside_image with done high for
	// one cycle, after the s1, s2, s3, divider, sa and sm registers; writes
	// return nothing. Results cannot be held off. Stores and reads reach the
	// frame memory in transfer order at the same stage, so a read sees every
	// earlier write. After reset and after any register write, busy is high
	// while the fit geometry is recomputed by a bit-serial divider. Frame
	// contents are not cleared: load the frame before reading it.

	localparam int XW    = $clog2(MAX_SOURCE_WIDTH);
	localparam int YW    = $clog2(MAX_SOURCE_HEIGHT);
	localparam int D     = (XW > YW) ? XW : YW;
	localparam int SWW   = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int SHW   = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int DW    = (SWW > SHW) ? SWW : SHW;
	localparam int NW    = afns_pkg::CoordW + DW;
	localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LAT   = 5 + D;
	localparam int CW    = afns_pkg::CoordW;

	// configuration registers
	logic [11:0] dw_q, dh_q;
	logic [9:0]  iw_q;
	logic [8:0]  ih_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= 12'd640;
			dh_q <= 12'd480;
			iw_q <= 10'd320;
			ih_q <= 9'd224;
		end else if (cfg_we) begin
			unique case (cfg_index)
				afns_pkg::CfgDispWidth:  dw_q <= cfg_data;
				afns_pkg::CfgDispHeight: dh_q <= cfg_data;
				afns_pkg::CfgImgWidth:   iw_q <= cfg_data[9:0];
				afns_pkg::CfgImgHeight:  ih_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// active image size, saturated to the store
	logic [12:0]   sw_sat, sh_sat;
	logic [DW-1:0] sw, sh;
	assign sw_sat = ({3'b0, iw_q} > 13'(MAX_SOURCE_WIDTH)) ? 13'(MAX_SOURCE_WIDTH) : {3'b0, iw_q};
	assign sh_sat = ({4'b0, ih_q} > 13'(MAX_SOURCE_HEIGHT)) ? 13'(MAX_SOURCE_HEIGHT) : {4'b0, ih_q};
	assign sw = DW'(sw_sat);
	assign sh = DW'(sh_sat);

	afns_pkg::geom_t geom;

	afns_geom #(.DW(DW)) u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (cfg_we),
		.dw     (dw_q),
		.dh     (dh_q),
		.sw     (sw),
		.sh     (sh),
		.busy   (busy),
		.geom   (geom)
	);

	logic acc;
	assign acc = start && !busy;

	// s1: capture transfer, check store bounds for writes
	logic          vld_s1;
	afns_pkg::side_t side_in;
	afns_pkg::side_t side_s1;

	always_comb begin
		side_in.op    = op;
		side_in.hit   = 1'b0;
		side_in.wr_ok = ({1'b0, coord_x} < 13'(MAX_SOURCE_WIDTH))
			&& ({1'b0, coord_y} < 13'(MAX_SOURCE_HEIGHT));
		side_in.cx    = coord_x;
		side_in.cy    = coord_y;
		side_in.pix   = pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
	end

	// s2: window test against the fitted image, local coordinates
	logic            vld_s2;
	afns_pkg::side_t side_win;
	afns_pkg::side_t side_s2;
	logic [CW-1:0]   lx_s2, ly_s2;
	logic            in_x, in_y;

	assign in_x = (side_s1.cx >= geom.xo)
		&& ({1'b0, side_s1.cx} < ({1'b0, geom.xo} + {1'b0, geom.fw}));
	assign in_y = (side_s1.cy >= geom.yo)
		&& ({1'b0, side_s1.cy} < ({1'b0, geom.yo} + {1'b0, geom.fh}));

	always_comb begin
		side_win     = side_s1;
		side_win.hit = geom.en && in_x && in_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_win;
		lx_s2   <= side_s1.cx - geom.xo;
		ly_s2   <= side_s1.cy - geom.yo;
	end

	// s3: scale by source size before the divide
	logic            vld_s3;
	afns_pkg::side_t side_s3;
	logic [NW-1:0]   nx_s3, ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		nx_s3   <= NW'(lx_s2) * NW'(sw);
		ny_s3   <= NW'(ly_s2) * NW'(sh);
	end

	// divider stages; quotient < source size, so no clamp is needed
	logic [D-1:0] qx, qy;

	afns_divpipe #(.NW(NW), .D(D)) u_div_x (
		.clk (clk), .num (nx_s3), .den (geom.fw), .quo (qx)
	);
	afns_divpipe #(.NW(NW), .D(D)) u_div_y (
		.clk (clk), .num (ny_s3), .den (geom.fh), .quo (qy)
	);

	logic            vld_d  [D+1];
	afns_pkg::side_t side_d [D+1];
	assign vld_d[0]  = vld_s3;
	assign side_d[0] = side_s3;

	for (genvar k = 0; k < D; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k+1] <= 1'b0;
			else         vld_d[k+1] <= vld_d[k];
		end
		always_ff @(posedge clk) begin
			side_d[k+1] <= side_d[k];
		end
	end

	// sa: frame address, row stride MAX_SOURCE_WIDTH
	logic              vld_sa, we_sa, inside_sa;
	logic [AW-1:0]     addr_sa;
	logic [afns_pkg::PixW-1:0] pix_sa;
	afns_pkg::side_t   sd;
	assign sd = side_d[D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			we_sa  <= 1'b0;
		end else begin
			vld_sa <= vld_d[D] && (sd.op == afns_pkg::OpRead);
			we_sa  <= vld_d[D] && (sd.op == afns_pkg::OpWrite) && sd.wr_ok;
		end
	end

	always_ff @(posedge clk) begin
		inside_sa <= sd.hit;
		pix_sa    <= sd.pix;
		if (sd.op == afns_pkg::OpRead)
			addr_sa <= AW'(AW'(qy[YW-1:0]) * AW'(MAX_SOURCE_WIDTH)) + AW'(qx[XW-1:0]);
		else
			addr_sa <= AW'(AW'(sd.cy[YW-1:0]) * AW'(MAX_SOURCE_WIDTH)) + AW'(sd.cx[XW-1:0]);
	end

	// sm: frame memory, one access per cycle, registered read
	logic [afns_pkg::PixW-1:0] mem [DEPTH];
	logic                      vld_sm, inside_sm;
	logic [afns_pkg::PixW-1:0] rd_sm;

	always_ff @(posedge clk) begin
		if (we_sa) mem[addr_sa] <= pix_sa;
		rd_sm     <= mem[addr_sa];
		inside_sm <= inside_sa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sm <= 1'b0;
		else         vld_sm <= vld_sa;
	end

	assign done         = vld_sm;
	assign inside_image = inside_sm;
	assign pixel_out    = inside_sm ? rd_sm : '0;

`ifndef SYNTHESIS
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc && op, LAT) |-> done)
		else $error("read result missing at fixed latency");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc && op, LAT))
		else $error("result without a read transfer");
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("geometry not recomputed after register write");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !inside_image) |-> (pixel_out == '0))
		else $error("background pixel not zero");
`endif

endmodule

@@ test/aspect_fit_nearest_scaler_unit_test.sv @@
// Self-checking bench for aspect_fit_nearest_scaler_unit: frame writes, letterboxed reads.
// Depends on afns_pkg and the scaler RTL; needs no files or arguments.
`timescale 1ns / 100ps

module aspect_fit_nearest_scaler_unit_test;

	localparam int SrcW = 512;
	localparam int SrcH = 256;
	localparam int SettleCycles = 64;   // headroom for pipeline / geometry recompute
	localparam int CycleLimit = 600000;

	typedef logic [afns_pkg::CoordW-1:0] coord_t;
	typedef logic [afns_pkg::PixW-1:0]   pix_t;

	typedef struct packed {
		pix_t pix;
		logic hit;
	} pixel_result_t;

	// directed row: an expected value is typed in only where has_exp is set
	typedef struct {
		logic   op;
		coord_t x;
		coord_t y;
		pix_t   pix;
		bit     has_exp;
		pix_t   exp_pix;
		logic   exp_in;
	} directed_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         op;
	coord_t                       coord_x;
	coord_t                       coord_y;
	pix_t                         pixel_in;
	logic                         cfg_we;
	logic [afns_pkg::CfgIdxW-1:0] cfg_index;
	logic [afns_pkg::CfgW-1:0]    cfg_data;
	logic                         done;
	pix_t                         pixel_out;
	logic                         inside_image;

	aspect_fit_nearest_scaler_unit #(
		.MAX_SOURCE_WIDTH (SrcW),
		.MAX_SOURCE_HEIGHT(SrcH)
	) dut (
		.clk, .arst_n, .start, .busy, .op, .coord_x, .coord_y, .pixel_in,
		.cfg_we, .cfg_index, .cfg_data, .done, .pixel_out, .inside_image
	);

	// shadow copy of the block's state
	pix_t        frame_copy [SrcW*SrcH];
	bit          frame_written [SrcW*SrcH];
	logic [11:0] disp_w, disp_h;
	logic [9:0]  img_w;
	logic [8:0]  img_h;

	pixel_result_t pending_pixels [$];
	int unsigned   fail_count;
	int unsigned   cycle_count;
	int            burst_left;
	bit            idling_on;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---- fitted geometry, as the block should derive it from the registers
	task automatic fit_geometry(output longint unsigned fw, output longint unsigned fh,
			output longint unsigned xo, output longint unsigned yo,
			output longint unsigned sw, output longint unsigned sh, output bit valid);
		longint unsigned dw, dh;
		dw = disp_w; dh = disp_h; sw = img_w; sh = img_h;
		if (sw > SrcW) sw = SrcW;   // oversized image registers saturate
		if (sh > SrcH) sh = SrcH;
		valid = !(sw == 0 || sh == 0 || dw == 0 || dh == 0);
		fw = 1; fh = 1; xo = 0; yo = 0;
		if (valid) begin
			if (dw * sh <= dh * sw) begin
				fw = dw; fh = (dw * sh) / sw;
			end else begin
				fh = dh; fw = (dh * sw) / sh;
			end
			if (fw == 0) fw = 1;
			if (fh == 0) fh = 1;
			xo = (dw - fw) / 2;
			yo = (dh - fh) / 2;
		end
	endtask

	// maps a display pixel to its source address; hit=0 means background
	task automatic map_display_pixel(input coord_t px, input coord_t py,
			output bit hit, output int unsigned addr);
		longint unsigned fw, fh, xo, yo, sw, sh, sx, sy;
		bit valid;
		fit_geometry(fw, fh, xo, yo, sw, sh, valid);
		hit = 1'b0; addr = 0;
		if (valid && px >= xo && px < xo + fw && py >= yo && py < yo + fh) begin
			sx = ((px - xo) * sw) / fw;
			sy = ((py - yo) * sh) / fh;
			if (sx > sw - 1) sx = sw - 1;
			if (sy > sh - 1) sy = sh - 1;
			hit = 1'b1;
			addr = int'(sy * SrcW + sx);
		end
	endtask

	// update shadow state for an accepted transfer and return the expected pixel
	task automatic scale_predict(input logic o, input coord_t x, input coord_t y,
			input pix_t p, output bit has_result, output pixel_result_t r);
		bit hit;
		int unsigned addr;
		has_result = 1'b0; r = '0;
		if (o == afns_pkg::OpWrite) begin
			if (x < SrcW && y < SrcH) begin
				frame_copy[y * SrcW + x] = p;
				frame_written[y * SrcW + x] = 1'b1;
			end
		end else begin
			map_display_pixel(x, y, hit, addr);
			has_result = 1'b1;
			r.hit = hit;
			r.pix = hit ? frame_copy[addr] : '0;
		end
	endtask

	// one transfer: drive at the falling edge, hold until start && !busy at a rising edge
	task automatic send_item(input logic o, input coord_t x, input coord_t y,
			input pix_t p, input bit use_typed, input pixel_result_t typed);
		bit has_result;
		pixel_result_t r;
		if (idling_on) begin
			if (burst_left <= 0) begin
				@(negedge clk);
				start = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		@(negedge clk);
		start = 1'b1; op = o; coord_x = x; coord_y = y; pixel_in = p;
		do @(posedge clk); while (busy);
		scale_predict(o, x, y, p, has_result, r);
		if (has_result)
			pending_pixels.push_back(use_typed ? typed : r);
	endtask

	// read that never lands on an unwritten source entry: fill it first
	task automatic send_read(input coord_t x, input coord_t y);
		bit hit;
		int unsigned addr;
		map_display_pixel(x, y, hit, addr);
		if (hit && !frame_written[addr])
			send_item(afns_pkg::OpWrite, coord_t'(addr % SrcW), coord_t'(addr / SrcW),
				$urandom, 1'b0, '0);
		send_item(afns_pkg::OpRead, x, y, '0, 1'b0, '0);
	endtask

	// wait until every expected pixel is back, then let the pipeline settle
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_register(input logic [afns_pkg::CfgIdxW-1:0] idx,
			input logic [afns_pkg::CfgW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			afns_pkg::CfgDispWidth:  disp_w = val[11:0];
			afns_pkg::CfgDispHeight: disp_h = val[11:0];
			afns_pkg::CfgImgWidth:   img_w = val[9:0];
			default:                 img_h = val[8:0];
		endcase
	endtask

	task automatic set_geometry(input int dw, input int dh, input int iw, input int ih);
		drain_results();
		write_register(afns_pkg::CfgDispWidth, dw[afns_pkg::CfgW-1:0]);
		write_register(afns_pkg::CfgDispHeight, dh[afns_pkg::CfgW-1:0]);
		write_register(afns_pkg::CfgImgWidth, iw[afns_pkg::CfgW-1:0]);
		write_register(afns_pkg::CfgImgHeight, ih[afns_pkg::CfgW-1:0]);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// mostly reads inside the fitted picture, plus writes and off-picture noise
	task automatic random_phase(input int n_items);
		longint unsigned fw, fh, xo, yo, sw, sh;
		bit valid;
		int k;
		fit_geometry(fw, fh, xo, yo, sw, sh, valid);
		for (k = 0; k < n_items; k++) begin
			case ($urandom_range(0, 9))
				0, 1: send_item(afns_pkg::OpWrite, coord_t'($urandom_range(0, SrcW - 1)),
						coord_t'($urandom_range(0, SrcH - 1)), $urandom, 1'b0, '0);
				2: send_item(afns_pkg::OpWrite, coord_t'($urandom), coord_t'($urandom),
						$urandom, 1'b0, '0);
				3: send_read(coord_t'($urandom), coord_t'($urandom));
				default: send_read(coord_t'(xo + $urandom_range(0, fw - 1)),
						coord_t'(yo + $urandom_range(0, fh - 1)));
			endcase
		end
	endtask

	// result side: the block presents each pixel for one cycle with done
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result pixel_out=%h inside_image=%b",
					$time, pixel_out, inside_image);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want.pix) begin
					$display("%0t: pixel_out expected %h actual %h", $time, want.pix, pixel_out);
					fail_count++;
				end
				if (inside_image !== want.hit) begin
					$display("%0t: inside_image expected %b actual %b",
						$time, want.hit, inside_image);
					fail_count++;
				end
			end
		end
	end

	directed_row_t directed [] = '{
		// reset geometry 640x480 <- 320x224: fitted 640x448 at y offset 16
		'{afns_pkg::OpRead,  12'd0,    12'd0,    32'h0,         1, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd4095, 12'd4095, 32'h0,         1, 32'h0,         1'b0},
		'{afns_pkg::OpWrite, 12'd0,    12'd0,    32'hFFFF_FFFF, 0, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd0,    12'd16,   32'h0,         1, 32'hFFFF_FFFF, 1'b1},
		'{afns_pkg::OpRead,  12'd0,    12'd15,   32'h0,         1, 32'h0,         1'b0},
		'{afns_pkg::OpWrite, 12'd319,  12'd223,  32'hA5A5_5A5A, 0, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd639,  12'd463,  32'h0,         1, 32'hA5A5_5A5A, 1'b1},
		'{afns_pkg::OpRead,  12'd640,  12'd463,  32'h0,         1, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd639,  12'd464,  32'h0,         1, 32'h0,         1'b0},
		// writes beyond the store are dropped; beyond the active image they land
		'{afns_pkg::OpWrite, 12'd512,  12'd0,    32'h1234_5678, 0, 32'h0,         1'b0},
		'{afns_pkg::OpWrite, 12'd0,    12'd256,  32'h1234_5678, 0, 32'h0,         1'b0},
		'{afns_pkg::OpWrite, 12'd4095, 12'd4095, 32'h1234_5678, 0, 32'h0,         1'b0},
		'{afns_pkg::OpWrite, 12'd511,  12'd255,  32'h0000_0001, 0, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd0,    12'd16,   32'h0,         1, 32'hFFFF_FFFF, 1'b1},
		'{afns_pkg::OpWrite, 12'd1,    12'd0,    32'h8000_0000, 0, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd2,    12'd16,   32'h0,         0, 32'h0,         1'b0},
		'{afns_pkg::OpRead,  12'd320,  12'd240,  32'h0,         0, 32'h0,         1'b0}
	};

	initial begin
		pixel_result_t typed;
		int i;
		fail_count = 0; cycle_count = 0; burst_left = 0; idling_on = 1'b1;
		start = 1'b0; op = afns_pkg::OpWrite; coord_x = '0; coord_y = '0; pixel_in = '0;
		cfg_we = 1'b0; cfg_index = afns_pkg::CfgDispWidth; cfg_data = '0;
		disp_w = 12'd640; disp_h = 12'd480; img_w = 10'd320; img_h = 9'd224;
		for (i = 0; i < SrcW * SrcH; i++) begin
			frame_copy[i] = '0;
			frame_written[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (SettleCycles) @(negedge clk);

		foreach (directed[i]) begin
			typed.pix = directed[i].exp_pix;
			typed.hit = directed[i].exp_in;
			if (directed[i].op == afns_pkg::OpRead && !directed[i].has_exp)
				send_read(directed[i].x, directed[i].y);
			else
				send_item(directed[i].op, directed[i].x, directed[i].y, directed[i].pix,
					directed[i].has_exp, typed);
		end
		random_phase(100);

		// extremes and the degenerate sizes; every third phase runs without gaps
		set_geometry(4095, 4095, 512, 256); idling_on = 1'b0; random_phase(130);
		set_geometry(1, 1, 1, 1);           idling_on = 1'b1; random_phase(80);
		set_geometry(4095, 1, 512, 1);      random_phase(110);
		set_geometry(1, 4095, 1, 256);      idling_on = 1'b0; random_phase(110);
		set_geometry(0, 480, 320, 224);     idling_on = 1'b1; random_phase(50);
		set_geometry(640, 0, 320, 224);     random_phase(50);
		set_geometry(100, 100, 0, 10);      idling_on = 1'b0; random_phase(50);
		set_geometry(100, 100, 10, 0);      idling_on = 1'b1; random_phase(50);
		set_geometry(800, 600, 1023, 511);  random_phase(130);
		set_geometry(2730, 1365, 341, 170); idling_on = 1'b0; random_phase(130);
		for (i = 0; i < 6; i++) begin
			idling_on = (i % 3) != 0;
			set_geometry($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 1023), $urandom_range(0, 511));
			random_phase(130);
		end

		drain_results();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
